/* src/tpcs_pkg.sv */
// Shared types and codes for the triangle/plane classify-and-split block.
package tpcs_pkg;

   localparam int VERTEX_WIDTH    = 48;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [1:0] {
      SIDE_FRONT    = 2'd0,
      SIDE_BACK     = 2'd1,
      SIDE_COPLANAR = 2'd2
   } side_type;

   typedef enum logic [1:0] {
      MODE_BAND    = 2'd0,
      MODE_EDGE_AC = 2'd1,
      MODE_EDGE_BC = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PLANE_VERTEX_0  = 3'd0,
      CSR_PLANE_VERTEX_1  = 3'd1,
      CSR_PLANE_VERTEX_2  = 3'd2,
      CSR_NEAR_ZERO_LIMIT = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [VERTEX_WIDTH-1:0] vertex_0;
      logic [VERTEX_WIDTH-1:0] vertex_1;
      logic [VERTEX_WIDTH-1:0] vertex_2;
   } req_payload_type;

   typedef struct packed {
      logic [VERTEX_WIDTH-1:0] out_vertex_0;
      logic [VERTEX_WIDTH-1:0] out_vertex_1;
      logic [VERTEX_WIDTH-1:0] out_vertex_2;
      logic [1:0]              side;
      logic                    last;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [VERTEX_WIDTH-1:0]    data;
   } csr_payload_type;

   typedef struct packed {
      logic [VERTEX_WIDTH-1:0] v0;
      logic [VERTEX_WIDTH-1:0] v1;
      logic [VERTEX_WIDTH-1:0] v2;
      side_type                side;
   } tri_type;

endpackage

/* src/tpcs_stream_if.sv */
// Valid/ready channel carrying one payload word per transaction.
interface tpcs_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* src/triangle_plane_classify_split.sv */
// Top level: pipelined triangle versus plane classifier and splitter.
// One triangle may enter every cycle while the pipeline advances; it holds while the
// output register has results waiting. The input register takes the triangle at the
// accepting edge, then come five stages for the plane determinants, classification and
// cut operands, then a restoring divider of COORD_WIDTH+3 stages (a setup stage, then one
// quotient bit each, six lanes for the two cut points), then the output register. A
// triangle that is passed through yields one result; a split yields two or three, handed
// out one per cycle from the output register while the sink is ready and the whole
// pipeline holds. Configuration writes are taken every cycle and must only be made
// while no triangle is in flight.
module triangle_plane_classify_split #(
   parameter int COORD_WIDTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   tpcs_stream_if.sink   req_chan,
   tpcs_stream_if.source rsp_chan,
   tpcs_stream_if.sink   csr_chan
);

   localparam int W    = COORD_WIDTH;
   localparam int DIFW = W + 1;
   localparam int NRMW = 2 * W + 3;
   localparam int PRDW = NRMW + DIFW;
   localparam int DW   = 3 * W + 7;
   localparam int CW   = ((DW > 49) ? DW : 49) + 1;
   localparam int RW   = DW + 1;
   localparam int QW   = DW + W + 1;
   localparam int NW   = DW + W + 3;
   localparam int DENW = DW + 2;
   localparam int Q    = W + 2;
   localparam int HL   = (DW + 1) / 2;
   localparam int HH   = DW - HL;
   localparam int VW   = tpcs_pkg::VERTEX_WIDTH;

   typedef struct packed {
      logic [2:0][VW-1:0]  word;
      logic                pass;
      tpcs_pkg::side_type  pass_side;
      logic                fa_back;
      tpcs_pkg::mode_type  mode;
      logic [1:0]          ia;
      logic [1:0]          ib;
      logic [1:0]          ic;
   } ctx_type;

   typedef struct packed {
      logic [DW-1:0]  dmag;
      logic [W:0]     fmag;
      logic [RW-1:0]  rmag;
      logic           neg;
      logic [W-1:0]   base;
   } opd_type;

   typedef struct packed {
      logic [HL+W:0]  plo;
      logic [HH+W:0]  phi;
      logic [RW-1:0]  rmag;
      logic           neg;
      logic [W-1:0]   base;
   } pp_type;

   typedef struct packed {
      logic [NW-1:0]   rem;
      logic [DENW-1:0] den;
      logic [Q-1:0]    quo;
      logic            neg;
      logic [W-1:0]    base;
   } div_type;

   function automatic logic signed [W-1:0] coord_of(input logic [VW-1:0] word, input int k);
      logic [63:0] ext;
      ext = 64'(word);
      return ext[k*W +: W];
   endfunction

   // configuration
   logic [2:0][VW-1:0] plane_ff;
   logic [VW-1:0]      limit_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
         limit_ff <= '0;
      end else if (csr_chan.valid) begin
         case (tpcs_pkg::csr_index_type'(csr_chan.payload.index))
            tpcs_pkg::CSR_PLANE_VERTEX_0:  plane_ff[0] <= csr_chan.payload.data;
            tpcs_pkg::CSR_PLANE_VERTEX_1:  plane_ff[1] <= csr_chan.payload.data;
            tpcs_pkg::CSR_PLANE_VERTEX_2:  plane_ff[2] <= csr_chan.payload.data;
            tpcs_pkg::CSR_NEAR_ZERO_LIMIT: limit_ff    <= csr_chan.payload.data;
            default: ;
         endcase
      end
   end

   // plane normal (b-a) x (c-a), refreshed every cycle from the registers
   logic signed [W-1:0]    pl [3][3];
   logic signed [DIFW-1:0] pu [3];
   logic signed [DIFW-1:0] pv [3];
   logic signed [NRMW-1:0] n_in [3];
   logic signed [NRMW-1:0] n_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            pl[j][k] = coord_of(plane_ff[j], k);
         end
      end
      for (int k = 0; k < 3; k++) begin
         pu[k] = DIFW'(pl[1][k]) - DIFW'(pl[0][k]);
         pv[k] = DIFW'(pl[2][k]) - DIFW'(pl[0][k]);
      end
      n_in[0] = NRMW'(pu[1] * pv[2]) - NRMW'(pu[2] * pv[1]);
      n_in[1] = NRMW'(pu[2] * pv[0]) - NRMW'(pu[0] * pv[2]);
      n_in[2] = NRMW'(pu[0] * pv[1]) - NRMW'(pu[1] * pv[0]);
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
   end

   // pipeline control: everything moves together, held while results drain
   logic       pipe_advance;
   logic       out_valid_ff;
   logic [1:0] out_idx_ff;
   logic [1:0] out_last_ff;

   assign pipe_advance   = !out_valid_ff || (rsp_chan.ready && (out_idx_ff == out_last_ff));
   assign req_chan.ready = pipe_advance;

   // s1: input register
   logic               s1_valid_ff;
   logic [2:0][VW-1:0] s1_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         s1_word_ff <= {req_chan.payload.vertex_2, req_chan.payload.vertex_1,
                        req_chan.payload.vertex_0};
      end
   end

   // s2: offsets from the first plane vertex
   logic                   s2_valid_ff;
   logic [2:0][VW-1:0]     s2_word_ff;
   logic signed [DIFW-1:0] s2_w_in [3][3];
   logic signed [DIFW-1:0] s2_w_ff [3][3];

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            s2_w_in[v][k] = DIFW'(coord_of(s1_word_ff[v], k)) - DIFW'(pl[0][k]);
         end
      end
   end

   // s3: partial dot products
   logic                   s3_valid_ff;
   logic [2:0][VW-1:0]     s3_word_ff;
   logic signed [PRDW-1:0] s3_prod_in [3][3];
   logic signed [PRDW-1:0] s3_prod_ff [3][3];

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            s3_prod_in[v][k] = n_ff[k] * s2_w_ff[v][k];
         end
      end
   end

   // s4: determinants
   logic                 s4_valid_ff;
   logic [2:0][VW-1:0]   s4_word_ff;
   logic signed [DW-1:0] s4_d_in [3];
   logic signed [DW-1:0] s4_d_ff [3];

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         s4_d_in[v] = -(DW'(s3_prod_ff[v][0]) + DW'(s3_prod_ff[v][1]) + DW'(s3_prod_ff[v][2]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         s2_word_ff <= s1_word_ff;
         s2_w_ff    <= s2_w_in;
         s3_word_ff <= s2_word_ff;
         s3_prod_ff <= s3_prod_in;
         s4_word_ff <= s3_word_ff;
         s4_d_ff    <= s4_d_in;
      end
   end

   // s5: classification, first crossing edge and cut operands
   logic signed [CW-1:0] lim;
   logic signed [CW-1:0] nlim;
   logic signed [CW-1:0] dext [3];
   logic [2:0]           inb;
   logic [2:0]           dpos;
   logic [2:0]           dneg;
   logic [2:0]           crossing;
   logic                 allz;
   logic                 allnn;
   logic                 allnp;
   logic                 c_pos;
   logic                 c_neg;
   ctx_type              s5_ctx_in;
   ctx_type              s5_ctx_ff;
   logic                 s5_valid_ff;
   opd_type              s5_opd_in [6];
   opd_type              s5_opd_ff [6];
   logic [VW-1:0]        p0w [2];
   logic [VW-1:0]        p1w [2];
   logic signed [DW-1:0] d0 [2];
   logic signed [DW-1:0] d1 [2];
   logic signed [RW-1:0] rdiff [2];
   logic signed [W-1:0]  c0 [6];
   logic signed [W-1:0]  c1 [6];
   logic signed [DIFW-1:0] fdiff [6];

   always_comb begin
      lim  = $signed(CW'(limit_ff));
      nlim = -lim;
      for (int v = 0; v < 3; v++) begin
         dext[v] = CW'(s4_d_ff[v]);
         inb[v]  = (dext[v] < lim) && (dext[v] > nlim);
         dneg[v] = s4_d_ff[v][DW-1];
         dpos[v] = !s4_d_ff[v][DW-1] && (s4_d_ff[v] != '0);
      end
      allz  = &inb;
      allnn = (dext[0] >= nlim) && (dext[1] >= nlim) && (dext[2] >= nlim);
      allnp = (dext[0] <= lim) && (dext[1] <= lim) && (dext[2] <= lim);
      crossing[0] = !inb[0] && !inb[1] && ((dpos[0] && dneg[1]) || (dneg[0] && dpos[1]));
      crossing[1] = !inb[1] && !inb[2] && ((dpos[1] && dneg[2]) || (dneg[1] && dpos[2]));
      crossing[2] = !inb[2] && !inb[0] && ((dpos[2] && dneg[0]) || (dneg[2] && dpos[0]));

      s5_ctx_in.word = s4_word_ff;
      s5_ctx_in.pass = allz || allnn || allnp;
      s5_ctx_in.pass_side = allz ? tpcs_pkg::SIDE_COPLANAR :
                            (allnn ? tpcs_pkg::SIDE_FRONT : tpcs_pkg::SIDE_BACK);
      if (crossing[0]) begin
         s5_ctx_in.ia = 2'd0; s5_ctx_in.ib = 2'd1; s5_ctx_in.ic = 2'd2;
      end else if (crossing[1]) begin
         s5_ctx_in.ia = 2'd1; s5_ctx_in.ib = 2'd2; s5_ctx_in.ic = 2'd0;
      end else if (crossing[2]) begin
         s5_ctx_in.ia = 2'd2; s5_ctx_in.ib = 2'd0; s5_ctx_in.ic = 2'd1;
      end else begin
         s5_ctx_in.ia = 2'd0; s5_ctx_in.ib = 2'd1; s5_ctx_in.ic = 2'd2;
      end
      s5_ctx_in.fa_back = !(dext[s5_ctx_in.ia] >= nlim);
      c_pos = dpos[s5_ctx_in.ic];
      c_neg = dneg[s5_ctx_in.ic];
      if (inb[s5_ctx_in.ic]) begin
         s5_ctx_in.mode = tpcs_pkg::MODE_BAND;
      end else if ((dpos[s5_ctx_in.ia] && c_pos) || (dneg[s5_ctx_in.ia] && c_neg)) begin
         s5_ctx_in.mode = tpcs_pkg::MODE_EDGE_BC;
      end else begin
         s5_ctx_in.mode = tpcs_pkg::MODE_EDGE_AC;
      end

      // cut 0 runs a to b; cut 1 runs a to c, or b to c when a and c share a side
      p0w[0] = s4_word_ff[s5_ctx_in.ia];
      p1w[0] = s4_word_ff[s5_ctx_in.ib];
      d0[0]  = s4_d_ff[s5_ctx_in.ia];
      d1[0]  = s4_d_ff[s5_ctx_in.ib];
      if (s5_ctx_in.mode == tpcs_pkg::MODE_EDGE_BC) begin
         p0w[1] = s4_word_ff[s5_ctx_in.ib];
         d0[1]  = s4_d_ff[s5_ctx_in.ib];
      end else begin
         p0w[1] = s4_word_ff[s5_ctx_in.ia];
         d0[1]  = s4_d_ff[s5_ctx_in.ia];
      end
      p1w[1] = s4_word_ff[s5_ctx_in.ic];
      d1[1]  = s4_d_ff[s5_ctx_in.ic];

      for (int j = 0; j < 2; j++) begin
         rdiff[j] = RW'(d0[j]) - RW'(d1[j]);
         for (int k = 0; k < 3; k++) begin
            c0[j*3+k]    = coord_of(p0w[j], k);
            c1[j*3+k]    = coord_of(p1w[j], k);
            fdiff[j*3+k] = DIFW'(c1[j*3+k]) - DIFW'(c0[j*3+k]);
            s5_opd_in[j*3+k].dmag = d0[j][DW-1] ? DW'(-d0[j]) : DW'(d0[j]);
            s5_opd_in[j*3+k].fmag = fdiff[j*3+k][W] ? DIFW'(-fdiff[j*3+k])
                                                    : DIFW'(fdiff[j*3+k]);
            s5_opd_in[j*3+k].rmag = rdiff[j][RW-1] ? RW'(-rdiff[j]) : RW'(rdiff[j]);
            s5_opd_in[j*3+k].neg  = d0[j][DW-1] ^ fdiff[j*3+k][W] ^ rdiff[j][RW-1];
            s5_opd_in[j*3+k].base = c0[j*3+k];
         end
      end
   end

   // s6: numerator magnitude as two partial products
   pp_type  s6_pp_in [6];
   pp_type  s6_pp_ff [6];
   ctx_type s6_ctx_ff;
   logic    s6_valid_ff;

   always_comb begin
      for (int l = 0; l < 6; l++) begin
         s6_pp_in[l].plo  = s5_opd_ff[l].dmag[HL-1:0] * s5_opd_ff[l].fmag;
         s6_pp_in[l].phi  = s5_opd_ff[l].dmag[DW-1:HL] * s5_opd_ff[l].fmag;
         s6_pp_in[l].rmag = s5_opd_ff[l].rmag;
         s6_pp_in[l].neg  = s5_opd_ff[l].neg;
         s6_pp_in[l].base = s5_opd_ff[l].base;
      end
   end

   // divider: stage 0 forms 2|q|+|r| over 2|r| (round half away from zero),
   // then one quotient bit per stage, most significant first
   logic    dv_valid_ff [Q+1];
   ctx_type dv_ctx_ff   [Q+1];
   div_type dv_lane_in  [Q+1][6];
   div_type dv_lane_ff  [Q+1][6];
   logic [QW-1:0] qmag [6];
   logic [NW-1:0] dshift [Q][6];

   always_comb begin
      for (int l = 0; l < 6; l++) begin
         qmag[l] = (QW'(s6_pp_ff[l].phi) << HL) + QW'(s6_pp_ff[l].plo);
         dv_lane_in[0][l].rem  = NW'({qmag[l], 1'b0}) + NW'(s6_pp_ff[l].rmag);
         dv_lane_in[0][l].den  = {s6_pp_ff[l].rmag, 1'b0};
         dv_lane_in[0][l].quo  = '0;
         dv_lane_in[0][l].neg  = s6_pp_ff[l].neg;
         dv_lane_in[0][l].base = s6_pp_ff[l].base;
      end
      for (int s = 0; s < Q; s++) begin
         for (int l = 0; l < 6; l++) begin
            dshift[s][l] = NW'(dv_lane_ff[s][l].den) << (Q - 1 - s);
            dv_lane_in[s+1][l] = dv_lane_ff[s][l];
            if (dv_lane_ff[s][l].rem >= dshift[s][l]) begin
               dv_lane_in[s+1][l].rem = dv_lane_ff[s][l].rem - dshift[s][l];
               dv_lane_in[s+1][l].quo[Q-1-s] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         for (int s = 0; s <= Q; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
      end else if (pipe_advance) begin
         s5_valid_ff    <= s4_valid_ff;
         s6_valid_ff    <= s5_valid_ff;
         dv_valid_ff[0] <= s6_valid_ff;
         for (int s = 0; s < Q; s++) begin
            dv_valid_ff[s+1] <= dv_valid_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         s5_ctx_ff    <= s5_ctx_in;
         s5_opd_ff    <= s5_opd_in;
         s6_ctx_ff    <= s5_ctx_ff;
         s6_pp_ff     <= s6_pp_in;
         dv_ctx_ff[0] <= s6_ctx_ff;
         for (int s = 0; s < Q; s++) begin
            dv_ctx_ff[s+1] <= dv_ctx_ff[s];
         end
         dv_lane_ff <= dv_lane_in;
      end
   end

   // cut points and result triangles
   ctx_type            fin_ctx;
   logic [W-1:0]       cut_coord [6];
   logic [3*W-1:0]     cut_pack [2];
   logic [63:0]        cut_ext [2];
   logic [VW-1:0]      i1;
   logic [VW-1:0]      i2;
   logic [VW-1:0]      va;
   logic [VW-1:0]      vb;
   logic [VW-1:0]      vc;
   tpcs_pkg::tri_type [2:0] tri_in;
   logic [1:0]         last_in;
   tpcs_pkg::tri_type [2:0] out_tri_ff;

   always_comb begin
      fin_ctx = dv_ctx_ff[Q];
      for (int l = 0; l < 6; l++) begin
         cut_coord[l] = dv_lane_ff[Q][l].base + (dv_lane_ff[Q][l].neg ?
                        W'(-dv_lane_ff[Q][l].quo[W-1:0]) : dv_lane_ff[Q][l].quo[W-1:0]);
      end
      for (int j = 0; j < 2; j++) begin
         cut_pack[j] = {cut_coord[j*3+2], cut_coord[j*3+1], cut_coord[j*3]};
         cut_ext[j]  = 64'(cut_pack[j]);
      end
      i1 = cut_ext[0][VW-1:0];
      i2 = cut_ext[1][VW-1:0];
      va = fin_ctx.word[fin_ctx.ia];
      vb = fin_ctx.word[fin_ctx.ib];
      vc = fin_ctx.word[fin_ctx.ic];
      tri_in  = '0;
      last_in = 2'd0;
      if (fin_ctx.pass) begin
         tri_in[0] = {fin_ctx.word[0], fin_ctx.word[1], fin_ctx.word[2], fin_ctx.pass_side};
      end else begin
         case (fin_ctx.mode)
            tpcs_pkg::MODE_BAND: begin
               last_in = 2'd1;
               if (!fin_ctx.fa_back) begin
                  tri_in[0] = {va, i1, vc, tpcs_pkg::SIDE_FRONT};
                  tri_in[1] = {vb, vc, i1, tpcs_pkg::SIDE_BACK};
               end else begin
                  tri_in[0] = {vb, vc, i1, tpcs_pkg::SIDE_FRONT};
                  tri_in[1] = {va, i1, vc, tpcs_pkg::SIDE_BACK};
               end
            end
            tpcs_pkg::MODE_EDGE_AC: begin
               last_in = 2'd2;
               if (!fin_ctx.fa_back) begin
                  tri_in[0] = {va, i1, i2, tpcs_pkg::SIDE_FRONT};
                  tri_in[1] = {vb, i2, i1, tpcs_pkg::SIDE_BACK};
                  tri_in[2] = {vb, vc, i2, tpcs_pkg::SIDE_BACK};
               end else begin
                  tri_in[0] = {vb, i2, i1, tpcs_pkg::SIDE_FRONT};
                  tri_in[1] = {vb, vc, i2, tpcs_pkg::SIDE_FRONT};
                  tri_in[2] = {va, i1, i2, tpcs_pkg::SIDE_BACK};
               end
            end
            tpcs_pkg::MODE_EDGE_BC: begin
               last_in = 2'd2;
               if (!fin_ctx.fa_back) begin
                  tri_in[0] = {va, i1, vc, tpcs_pkg::SIDE_FRONT};
                  tri_in[1] = {vc, i1, i2, tpcs_pkg::SIDE_FRONT};
                  tri_in[2] = {vb, i2, i1, tpcs_pkg::SIDE_BACK};
               end else begin
                  tri_in[0] = {vb, i2, i1, tpcs_pkg::SIDE_FRONT};
                  tri_in[1] = {va, i1, vc, tpcs_pkg::SIDE_BACK};
                  tri_in[2] = {vc, i1, i2, tpcs_pkg::SIDE_BACK};
               end
            end
            default: ;
         endcase
      end
   end

   // output register: results of one item go out one per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_idx_ff   <= 2'd0;
         out_last_ff  <= 2'd0;
      end else if (pipe_advance) begin
         out_valid_ff <= dv_valid_ff[Q];
         out_idx_ff   <= 2'd0;
         out_last_ff  <= last_in;
      end else if (rsp_chan.ready) begin
         out_idx_ff <= out_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         out_tri_ff <= tri_in;
      end
   end

   assign rsp_chan.valid                = out_valid_ff;
   assign rsp_chan.payload.out_vertex_0 = out_tri_ff[out_idx_ff].v0;
   assign rsp_chan.payload.out_vertex_1 = out_tri_ff[out_idx_ff].v1;
   assign rsp_chan.payload.out_vertex_2 = out_tri_ff[out_idx_ff].v2;
   assign rsp_chan.payload.side         = out_tri_ff[out_idx_ff].side;
   assign rsp_chan.payload.last         = (out_idx_ff == out_last_ff);

endmodule

/* src/tpcs_checker.sv */
// Port-level checks for the classify-and-split block, bound to its top level.
module tpcs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input tpcs_pkg::rsp_payload_type rsp_payload
);

   // a result held back by the sink keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // the rest of a split is already waiting in the output register
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last |=> rsp_valid)
      else $error("gap inside the results of one triangle");

   // coplanar triangles are never split
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.side == tpcs_pkg::SIDE_COPLANAR) |-> rsp_payload.last)
      else $error("coplanar result not marked last");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind triangle_plane_classify_split tpcs_checker u_tpcs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

/* test/triangle_split_checker.sv */
// Checker: watches the channels, predicts each triangle's results and compares them.
module triangle_split_checker #(
   parameter int COORD_WIDTH = 16
) (
   input  logic   clock,
   input  logic   reset,
   tpcs_stream_if req_chan,
   tpcs_stream_if rsp_chan,
   tpcs_stream_if csr_chan,
   output int     fail_count,
   output int     pending,
   output int     triangles_seen,
   output int     results_seen,
   output int     splits_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } point_type;
   typedef logic signed [127:0] wide_type;

   localparam logic [63:0] COORD_MASK = (64'd1 << COORD_WIDTH) - 64'd1;
   localparam logic [63:0] SIGN_BIT   = 64'd1 << (COORD_WIDTH - 1);

   logic [47:0]               plane_reg [3];
   logic [47:0]               limit_reg;
   tpcs_pkg::rsp_payload_type expected_tris [$];

   initial begin
      fail_count     = 0;
      pending        = 0;
      triangles_seen = 0;
      results_seen   = 0;
      splits_seen    = 0;
      plane_reg[0]   = '0;
      plane_reg[1]   = '0;
      plane_reg[2]   = '0;
      limit_reg      = '0;
   end

   function automatic logic signed [63:0] coord_of(logic [47:0] w, int k);
      logic [63:0]        raw;
      logic signed [63:0] s;
      raw = ({16'b0, w} >> (k * COORD_WIDTH)) & COORD_MASK;
      s = $signed(raw ^ SIGN_BIT) - $signed(SIGN_BIT);
      return s;
   endfunction

   function automatic point_type to_point(logic [47:0] w);
      point_type p;
      p.x = coord_of(w, 0);
      p.y = coord_of(w, 1);
      p.z = coord_of(w, 2);
      return p;
   endfunction

   function automatic logic [47:0] to_word(point_type p);
      logic [63:0] r;
      r = (p.x & COORD_MASK) | ((p.y & COORD_MASK) << COORD_WIDTH)
          | ((p.z & COORD_MASK) << (2 * COORD_WIDTH));
      return r[47:0];
   endfunction

   // -((b-a) x (c-a)) . (p-a), exact
   function automatic wide_type plane_det(point_type p);
      point_type a, b, c;
      wide_type  ux, uy, uz, vx, vy, vz, wx, wy, wz, s;
      a = to_point(plane_reg[0]);
      b = to_point(plane_reg[1]);
      c = to_point(plane_reg[2]);
      ux = b.x - a.x; uy = b.y - a.y; uz = b.z - a.z;
      vx = c.x - a.x; vy = c.y - a.y; vz = c.z - a.z;
      wx = p.x - a.x; wy = p.y - a.y; wz = p.z - a.z;
      s = (uy * vz - uz * vy) * wx + (uz * vx - ux * vz) * wy + (ux * vy - uy * vx) * wz;
      return -s;
   endfunction

   function automatic int sign_of(wide_type v);
      if (v < 0) return -1;
      return (v != 0) ? 1 : 0;
   endfunction

   // nearest integer, halves away from zero
   function automatic wide_type div_round(wide_type q, wide_type r);
      logic [127:0] aq, ar, quo;
      wide_type     res;
      aq = (q < 0) ? -q : q;
      ar = (r < 0) ? -r : r;
      if (ar == 0) return 0;
      quo = ((aq << 1) + ar) / (ar << 1);
      quo = quo & ((128'd1 << 40) - 128'd1);
      res = $signed(quo);
      return ((q < 0) != (r < 0)) ? -res : res;
   endfunction

   function automatic logic [47:0] cut_point(point_type a, point_type b, wide_type da,
                                             wide_type db);
      wide_type  r, dx, dy, dz;
      point_type p;
      r  = da - db;
      dx = b.x - a.x;
      dy = b.y - a.y;
      dz = b.z - a.z;
      p.x = a.x + ((r == 0) ? 0 : div_round(da * dx, r));
      p.y = a.y + ((r == 0) ? 0 : div_round(da * dy, r));
      p.z = a.z + ((r == 0) ? 0 : div_round(da * dz, r));
      return to_word(p);
   endfunction

   task automatic queue_tri(logic [47:0] v0, logic [47:0] v1, logic [47:0] v2,
                            tpcs_pkg::side_type s);
      tpcs_pkg::rsp_payload_type e;
      e.out_vertex_0 = v0;
      e.out_vertex_1 = v1;
      e.out_vertex_2 = v2;
      e.side         = s;
      e.last         = 1'b0;
      expected_tris = {expected_tris, e};
   endtask

   task automatic predict_split(tpcs_pkg::req_payload_type t);
      logic [47:0] word [3];
      point_type   pt [3];
      wide_type    d [3];
      wide_type    lim, nlim;
      logic        inband [3];
      logic        all_band, all_front, all_back, a_front;
      int          ia, ib, ic, sa, sc;
      logic [47:0] a, b, c, i1, i2;
      word[0] = t.vertex_0;
      word[1] = t.vertex_1;
      word[2] = t.vertex_2;
      lim  = $signed({80'b0, limit_reg});
      nlim = -lim;
      all_band = 1'b1; all_front = 1'b1; all_back = 1'b1;
      for (int i = 0; i < 3; i++) begin
         pt[i] = to_point(word[i]);
         d[i]  = plane_det(pt[i]);
         inband[i] = (d[i] < lim) && (d[i] > nlim);
         all_band  = all_band && inband[i];
         all_front = all_front && (d[i] >= nlim);
         all_back  = all_back && (d[i] <= lim);
      end
      if (all_band || all_front || all_back) begin
         queue_tri(word[0], word[1], word[2],
                   all_band ? tpcs_pkg::SIDE_COPLANAR :
                   (all_front ? tpcs_pkg::SIDE_FRONT : tpcs_pkg::SIDE_BACK));
      end else begin
         splits_seen++;
         ia = 0; ib = 1;
         for (int i = 2; i >= 0; i--) begin
            int j;
            j = (i + 1) % 3;
            if (!inband[i] && !inband[j] && sign_of(d[i]) * sign_of(d[j]) < 0) begin
               ia = i;
               ib = j;
            end
         end
         ic = (ib + 1) % 3;
         a = word[ia]; b = word[ib]; c = word[ic];
         a_front = d[ia] >= nlim;
         sa = sign_of(d[ia]);
         sc = sign_of(d[ic]);
         i1 = cut_point(pt[ia], pt[ib], d[ia], d[ib]);
         if (inband[ic]) begin
            if (a_front) begin
               queue_tri(a, i1, c, tpcs_pkg::SIDE_FRONT);
               queue_tri(b, c, i1, tpcs_pkg::SIDE_BACK);
            end else begin
               queue_tri(b, c, i1, tpcs_pkg::SIDE_FRONT);
               queue_tri(a, i1, c, tpcs_pkg::SIDE_BACK);
            end
         end else if (sa * sc <= 0) begin
            i2 = cut_point(pt[ia], pt[ic], d[ia], d[ic]);
            if (a_front) begin
               queue_tri(a, i1, i2, tpcs_pkg::SIDE_FRONT);
               queue_tri(b, i2, i1, tpcs_pkg::SIDE_BACK);
               queue_tri(b, c, i2, tpcs_pkg::SIDE_BACK);
            end else begin
               queue_tri(b, i2, i1, tpcs_pkg::SIDE_FRONT);
               queue_tri(b, c, i2, tpcs_pkg::SIDE_FRONT);
               queue_tri(a, i1, i2, tpcs_pkg::SIDE_BACK);
            end
         end else begin
            i2 = cut_point(pt[ib], pt[ic], d[ib], d[ic]);
            if (a_front) begin
               queue_tri(a, i1, c, tpcs_pkg::SIDE_FRONT);
               queue_tri(c, i1, i2, tpcs_pkg::SIDE_FRONT);
               queue_tri(b, i2, i1, tpcs_pkg::SIDE_BACK);
            end else begin
               queue_tri(b, i2, i1, tpcs_pkg::SIDE_FRONT);
               queue_tri(a, i1, c, tpcs_pkg::SIDE_BACK);
               queue_tri(c, i1, i2, tpcs_pkg::SIDE_BACK);
            end
         end
      end
      expected_tris[expected_tris.size() - 1].last = 1'b1;
   endtask

   task automatic report(string what, logic [63:0] want, logic [63:0] got);
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      tpcs_pkg::rsp_payload_type got, want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            results_seen++;
            if (expected_tris.size() == 0) begin
               report("unexpected result transaction", '0, got.out_vertex_0);
            end else begin
               want = expected_tris.pop_front();
               if (got.out_vertex_0 !== want.out_vertex_0)
                  report("out_vertex_0", want.out_vertex_0, got.out_vertex_0);
               if (got.out_vertex_1 !== want.out_vertex_1)
                  report("out_vertex_1", want.out_vertex_1, got.out_vertex_1);
               if (got.out_vertex_2 !== want.out_vertex_2)
                  report("out_vertex_2", want.out_vertex_2, got.out_vertex_2);
               if (got.side !== want.side) report("side", want.side, got.side);
               if (got.last !== want.last) report("last", want.last, got.last);
            end
         end
         if (csr_chan.valid && csr_chan.ready) begin
            case (tpcs_pkg::csr_index_type'(csr_chan.payload.index))
               tpcs_pkg::CSR_PLANE_VERTEX_0:  plane_reg[0] = csr_chan.payload.data;
               tpcs_pkg::CSR_PLANE_VERTEX_1:  plane_reg[1] = csr_chan.payload.data;
               tpcs_pkg::CSR_PLANE_VERTEX_2:  plane_reg[2] = csr_chan.payload.data;
               tpcs_pkg::CSR_NEAR_ZERO_LIMIT: limit_reg    = csr_chan.payload.data;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            triangles_seen++;
            predict_split(req_chan.payload);
         end
      end
      pending = expected_tris.size();
   end

endmodule

/* test/triangle_plane_classify_split_tb.sv */
// Testbench top: clock, reset, stimulus and verdict for the classify-and-split block.
module triangle_plane_classify_split_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_WIDTH = 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE      = COORD_WIDTH + 20;

   logic clock;
   logic reset;
   int   cycles;
   int   fail_count, pending, triangles_seen, results_seen, splits_seen;
   logic no_idle;
   logic hold_request;
   int   hold_left;
   int   stall_left;

   tpcs_stream_if #(.payload_type(tpcs_pkg::req_payload_type)) req_chan ();
   tpcs_stream_if #(.payload_type(tpcs_pkg::rsp_payload_type)) rsp_chan ();
   tpcs_stream_if #(.payload_type(tpcs_pkg::csr_payload_type)) csr_chan ();

   triangle_plane_classify_split #(.COORD_WIDTH(COORD_WIDTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   triangle_split_checker #(.COORD_WIDTH(COORD_WIDTH)) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_chan       (csr_chan),
      .fail_count     (fail_count),
      .pending        (pending),
      .triangles_seen (triangles_seen),
      .results_seen   (results_seen),
      .splits_seen    (splits_seen)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = 400;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready = 1'b1;
            stall_left = gap_len();
         end
      end
   end

   function automatic logic [47:0] pt(int x, int y, int z);
      logic [15:0] xs, ys, zs;
      xs = x[15:0];
      ys = y[15:0];
      zs = z[15:0];
      return {zs, ys, xs};
   endfunction

   function automatic int srand(int r);
      return $urandom_range(0, 2 * r) - r;
   endfunction

   function automatic logic [47:0] any_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[47:0];
   endfunction

   task automatic send_tri(logic [47:0] a, logic [47:0] b, logic [47:0] c);
      int g;
      g = gap_len();
      @(negedge clock);
      if (g > 0) begin
         req_chan.valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_chan.payload = '{vertex_0: a, vertex_1: b, vertex_2: c};
      req_chan.valid   = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(tpcs_pkg::csr_index_type idx, logic [47:0] data);
      @(negedge clock);
      csr_chan.payload = '{index: idx, data: data};
      csr_chan.valid   = 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic set_plane(logic [47:0] p0, logic [47:0] p1, logic [47:0] p2,
                            logic [47:0] lim);
      drain();
      csr_write(tpcs_pkg::CSR_PLANE_VERTEX_0, p0);
      csr_write(tpcs_pkg::CSR_PLANE_VERTEX_1, p1);
      csr_write(tpcs_pkg::CSR_PLANE_VERTEX_2, p2);
      csr_write(tpcs_pkg::CSR_NEAR_ZERO_LIMIT, lim);
   endtask

   // mostly small coordinates so that splits are common; some full-range noise
   task automatic random_tris(int count, int span, int noise_pct);
      logic [47:0] v [3];
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 99) < noise_pct) v[k] = any_word();
            else v[k] = pt(srand(span), srand(span), srand(span));
         end
         send_tri(v[0], v[1], v[2]);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      no_idle         = 1'b0;
      hold_request    = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.payload = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // reset values: degenerate plane, everything passes through on the front side
      send_tri(pt(1, 2, 3), pt(-4, 5, -6), pt(7, -8, 9));
      send_tri(48'hffff_ffff_ffff, 48'h0, 48'h8000_8000_8000);

      // plane z = 0, so the determinant is -z: front is z <= 0
      set_plane(pt(0, 0, 0), pt(1, 0, 0), pt(0, 1, 0), 48'd0);
      send_tri(pt(1, 1, -1), pt(5, 2, -3), pt(-2, 4, 0));
      send_tri(pt(1, 1, 1), pt(5, 2, 3), pt(-2, 4, 0));
      send_tri(pt(1, 1, 0), pt(5, 2, 0), pt(-2, 4, 0));
      send_tri(pt(0, 0, -4), pt(8, 0, 4), pt(3, 9, 0));
      send_tri(pt(0, 0, 4), pt(8, 0, -4), pt(3, 9, 0));
      send_tri(pt(0, 0, -4), pt(8, 0, 4), pt(3, 9, 4));
      send_tri(pt(0, 0, 4), pt(8, 0, -4), pt(3, 9, -4));
      send_tri(pt(0, 0, -4), pt(8, 0, 4), pt(3, 9, -6));
      send_tri(pt(0, 0, 4), pt(8, 0, -4), pt(3, 9, 6));
      send_tri(pt(0, 0, 4), pt(8, 0, 4), pt(3, 9, -4));
      send_tri(pt(0, 0, 0), pt(8, 0, 4), pt(3, 9, -4));
      send_tri(pt(0, 0, -1), pt(3, 3, 1), pt(-3, 7, 2));
      send_tri(pt(0, 0, -1), pt(-3, -3, 1), pt(3, 7, -2));
      send_tri(pt(0, 0, -1), pt(2, 5, 2), pt(1, 1, 5));
      send_tri(48'hffff_ffff_ffff, 48'h0000_0000_0000, 48'h7fff_7fff_7fff);
      send_tri(pt(-32768, 32767, -32768), pt(32767, -32768, 32767),
               pt(0, 0, 32767));

      // near-zero band of a few units
      set_plane(pt(0, 0, 0), pt(1, 0, 0), pt(0, 1, 0), 48'd3);
      send_tri(pt(0, 0, -2), pt(8, 0, 2), pt(3, 9, 1));
      send_tri(pt(0, 0, -3), pt(8, 0, 5), pt(3, 9, 2));
      random_tris(50, 12, 5);

      // general plane with a random band; the result side holds off for a while
      set_plane(pt(srand(60), srand(60), srand(60)), pt(srand(60), srand(60), srand(60)),
                pt(srand(60), srand(60), srand(60)), $urandom_range(0, 200000));
      @(negedge clock);
      hold_request = 1'b1;
      random_tris(70, 300, 10);

      // band wide enough to swallow everything
      set_plane(pt(3, -7, 11), pt(-20, 5, 9), pt(14, 2, -30), 48'hffff_ffff_ffff);
      random_tris(8, 32767, 50);

      // extreme plane vertices, no band
      set_plane(pt(-32768, -32768, 32767), pt(32767, -32768, -32768),
                pt(-32768, 32767, -32768), 48'd0);
      random_tris(50, 32767, 40);

      // full-range plane and band
      set_plane(any_word(), any_word(), any_word(), any_word());
      random_tris(20, 32767, 50);

      set_plane(pt(srand(200), srand(200), srand(200)), pt(srand(200), srand(200), srand(200)),
                pt(srand(200), srand(200), srand(200)), $urandom_range(0, 1000));
      random_tris(40, 500, 5);

      drain();
      $display("tb: %0d triangles sent over eight plane settings, %0d split", triangles_seen,
               splits_seen);
      $display("tb: %0d result transactions checked, %0d mismatches", results_seen,
               fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/tpcs_pkg.sv
src/tpcs_stream_if.sv
src/triangle_plane_classify_split.sv
src/tpcs_checker.sv
test/triangle_split_checker.sv
test/triangle_plane_classify_split_tb.sv
